/* rtl/mbhp_pkg.sv */
// package for the media box header parser
// shared widths, the wide-box tag and the type character check
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbhp_pkg;

  localparam int BYTE_W = 8;
  localparam int TYPE_W = 32;
  localparam int SIZE_W = 64;
  localparam int FLEN_W = 48;

  // header is a 32-bit size and a 4-character type
  localparam logic [SIZE_W-1:0] HDR_BYTES = 64'd8;
  localparam logic [TYPE_W-1:0] WIDE_TAG  = 32'h7769_6465;
  localparam logic [TYPE_W-1:0] EXT_SIZE  = 32'd1;

  typedef struct packed {
    logic [TYPE_W-1:0] box_type;
    logic              not_letters;
  } box_tag_t;

  function automatic logic type_bad(input logic [TYPE_W-1:0] t);
    logic [BYTE_W-1:0] c;
    logic              bad;
    bad = 1'b0;
    for (int k = 0; k < TYPE_W / BYTE_W; k++) begin
      c = t[k*BYTE_W +: BYTE_W];
      if (!((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

endpackage

`default_nettype wire

/* rtl/mbhp_in_if.sv */
// input channel: one header byte per item with valid/ready
// depends on mbhp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mbhp_in_if #(
  parameter int OFFSET_BITS = 48
) ();
  import mbhp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BYTE_W-1:0]      header_byte;
  logic                   begins_header;
  logic [OFFSET_BITS-1:0] byte_offset;

  modport source(output valid, header_byte, begins_header, byte_offset, input ready);
  modport sink(input valid, header_byte, begins_header, byte_offset, output ready);
endinterface

`default_nettype wire

/* rtl/mbhp_out_if.sv */
// result channel: one parsed box header per item with valid/ready
// depends on mbhp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mbhp_out_if #(
  parameter int OFFSET_BITS = 48
) ();
  import mbhp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TYPE_W-1:0]      box_type;
  logic [OFFSET_BITS-1:0] box_start;
  logic [SIZE_W-1:0]      box_size;
  logic [SIZE_W-1:0]      box_end;
  logic                   type_not_letters;

  modport source(output valid, box_type, box_start, box_size, box_end, type_not_letters,
                 input ready);
  modport sink(input valid, box_type, box_start, box_size, box_end, type_not_letters,
               output ready);
endinterface

`default_nettype wire

/* rtl/mbhp_parse.sv */
// header parse stage: byte window, phase tracking and size resolution
// depends on mbhp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbhp_parse #(
  parameter int OFFSET_BITS = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire logic                           a_valid,
  input  wire logic [mbhp_pkg::BYTE_W-1:0]    a_byte,
  input  wire logic                           a_begins,
  input  wire logic [OFFSET_BITS-1:0]         a_offset,
  input  wire logic [mbhp_pkg::FLEN_W-1:0]    file_length,
  output      logic                           res_valid,
  output      mbhp_pkg::box_tag_t             res_tag,
  output      logic [OFFSET_BITS-1:0]         res_start,
  output      logic [mbhp_pkg::SIZE_W-1:0]    res_size
);
  import mbhp_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_MAIN, PH_EXT, PH_WIDE} phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             seen_r, seen_nxt;
  logic [SIZE_W-1:0]      window_r, window_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [SIZE_W-1:0]      saved_size_r, saved_size_nxt;
  box_tag_t               saved_tag_r, saved_tag_nxt;

  logic                   res_valid_r, res_valid_nxt;
  box_tag_t               res_tag_r, res_tag_nxt;
  logic [OFFSET_BITS-1:0] res_start_r, res_start_nxt;
  logic [SIZE_W-1:0]      res_size_r, res_size_nxt;

  phase_t                 phase_eff;
  logic [2:0]             seen_eff;
  logic [SIZE_W-1:0]      window_eff;
  logic [OFFSET_BITS-1:0] start_eff;
  logic [SIZE_W-1:0]      window_new;
  logic [TYPE_W-1:0]      raw;
  logic [TYPE_W-1:0]      typ;
  logic                   typ_bad;
  logic [SIZE_W-1:0]      size_small;
  logic [SIZE_W-1:0]      size_ext;
  logic [SIZE_W-1:0]      size_wrap;

  always_comb begin
    // a marked byte restarts the parse before it is shifted in
    if (a_begins) begin
      phase_eff  = PH_MAIN;
      seen_eff   = '0;
      window_eff = '0;
      start_eff  = a_offset;
    end else begin
      phase_eff  = phase_r;
      seen_eff   = seen_r;
      window_eff = window_r;
      start_eff  = start_r;
    end
    window_new = {window_eff[SIZE_W-BYTE_W-1:0], a_byte};
    raw        = window_new[SIZE_W-1:TYPE_W];
    typ        = window_new[TYPE_W-1:0];
    typ_bad    = type_bad(typ);

    // raw size 0 runs to end of file, 1..7 clamp to a bare header
    if (raw == '0) begin
      size_small = SIZE_W'(file_length) - SIZE_W'(start_eff);
    end else if (SIZE_W'(raw) < HDR_BYTES) begin
      size_small = HDR_BYTES;
    end else begin
      size_small = SIZE_W'(raw);
    end
    size_ext  = (window_new < HDR_BYTES) ? HDR_BYTES : window_new;
    size_wrap = (saved_size_r == HDR_BYTES) ? size_small : saved_size_r - HDR_BYTES;
  end

  always_comb begin
    phase_nxt      = phase_r;
    seen_nxt       = seen_r;
    window_nxt     = window_r;
    start_nxt      = start_r;
    saved_size_nxt = saved_size_r;
    saved_tag_nxt  = saved_tag_r;
    res_valid_nxt  = res_valid_r;
    res_tag_nxt    = res_tag_r;
    res_start_nxt  = res_start_r;
    res_size_nxt   = res_size_r;

    if (adv) begin
      res_valid_nxt = 1'b0;
      if (a_valid && phase_eff != PH_IDLE) begin
        phase_nxt  = phase_eff;
        seen_nxt   = seen_eff + 3'd1;
        window_nxt = window_new;
        start_nxt  = start_eff;
        if (seen_eff == 3'd7) begin
          unique case (phase_eff)
            PH_MAIN: begin
              saved_tag_nxt = '{box_type: typ, not_letters: typ_bad};
              if (typ == WIDE_TAG) begin
                saved_size_nxt = size_small;
                start_nxt      = start_eff + OFFSET_BITS'(HDR_BYTES);
                phase_nxt      = PH_WIDE;
                window_nxt     = '0;
              end else if (raw == EXT_SIZE) begin
                phase_nxt  = PH_EXT;
                window_nxt = '0;
              end else begin
                res_valid_nxt = 1'b1;
                res_tag_nxt   = '{box_type: typ, not_letters: typ_bad};
                res_start_nxt = start_eff;
                res_size_nxt  = size_small;
                phase_nxt     = PH_IDLE;
              end
            end
            PH_EXT: begin
              res_valid_nxt = 1'b1;
              res_tag_nxt   = saved_tag_r;
              res_start_nxt = start_eff;
              res_size_nxt  = size_ext;
              phase_nxt     = PH_IDLE;
            end
            PH_WIDE: begin
              res_valid_nxt = 1'b1;
              res_tag_nxt   = '{box_type: typ, not_letters: typ_bad};
              res_start_nxt = start_eff;
              res_size_nxt  = size_wrap;
              phase_nxt     = PH_IDLE;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seen_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seen_r      <= seen_nxt;
      res_valid_r <= res_valid_nxt;
    end
    window_r     <= window_nxt;
    start_r      <= start_nxt;
    saved_size_r <= saved_size_nxt;
    saved_tag_r  <= saved_tag_nxt;
    res_tag_r    <= res_tag_nxt;
    res_start_r  <= res_start_nxt;
    res_size_r   <= res_size_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_tag   = res_tag_r;
  assign res_start = res_start_r;
  assign res_size  = res_size_r;

  // byte count only runs while a header is being gathered
  a_idle_count : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> seen_r == 3'd0)
    else $error("byte count nonzero while idle");

  // a stalled pipeline leaves the parse state untouched
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(phase_r) && $stable(seen_r) && $stable(res_valid_r))
    else $error("parse state moved during stall");

  // a result needs a byte in the input stage
  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    adv && !a_valid |=> !res_valid_r)
    else $error("result without an input byte");

endmodule

`default_nettype wire

/* rtl/mbhp_emit.sv */
// output stage: end offset add and result register
// depends on mbhp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbhp_emit #(
  parameter int OFFSET_BITS = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        res_valid,
  input  wire mbhp_pkg::box_tag_t          res_tag,
  input  wire logic [OFFSET_BITS-1:0]      res_start,
  input  wire logic [mbhp_pkg::SIZE_W-1:0] res_size,
  mbhp_out_if.source                       out_chan
);
  import mbhp_pkg::*;

  logic                   out_valid_r;
  box_tag_t               out_tag_r;
  logic [OFFSET_BITS-1:0] out_start_r;
  logic [SIZE_W-1:0]      out_size_r;
  logic [SIZE_W-1:0]      out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
    if (adv) begin
      out_tag_r   <= res_tag;
      out_start_r <= res_start;
      out_size_r  <= res_size;
      // wraps modulo 2^64
      out_end_r   <= SIZE_W'(res_start) + res_size;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.box_type         = out_tag_r.box_type;
  assign out_chan.type_not_letters = out_tag_r.not_letters;
  assign out_chan.box_start        = out_start_r;
  assign out_chan.box_size         = out_size_r;
  assign out_chan.box_end          = out_end_r;

endmodule

`default_nettype wire

/* rtl/media_box_header_parser_core.sv */
// Media box header parser, top level: input register, parse stage, output stage.
// The byte that completes a header passes the input register, parse register and output register to out valid.
// Throughput: one byte per cycle; all stages hold together while a result waits.
// Reset (rst_n low, synchronous) idles the parser, empties the pipeline and
// clears file_length to zero.
// Depends on mbhp_pkg, mbhp_in_if, mbhp_out_if, mbhp_parse, mbhp_emit.
`timescale 1ns / 1ps
`default_nettype none

module media_box_header_parser_core #(
  parameter int OFFSET_BITS = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [mbhp_pkg::FLEN_W-1:0] cfg_wdata,
  mbhp_in_if.sink                          in_chan,
  mbhp_out_if.source                       out_chan
);
  import mbhp_pkg::*;

  logic                   adv;
  logic [FLEN_W-1:0]      file_length_r;
  logic                   a_valid_r;
  logic [BYTE_W-1:0]      a_byte_r;
  logic                   a_begins_r;
  logic [OFFSET_BITS-1:0] a_offset_r;
  logic                   res_valid;
  box_tag_t               res_tag;
  logic [OFFSET_BITS-1:0] res_start;
  logic [SIZE_W-1:0]      res_size;

  // the whole pipeline moves unless the output holds an untaken result
  assign adv           = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
      a_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        file_length_r <= cfg_wdata;
      end
      if (adv) begin
        a_valid_r <= in_chan.valid;
      end
    end
    if (adv) begin
      a_byte_r   <= in_chan.header_byte;
      a_begins_r <= in_chan.begins_header;
      a_offset_r <= in_chan.byte_offset;
    end
  end

  mbhp_parse #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .a_valid    (a_valid_r),
    .a_byte     (a_byte_r),
    .a_begins   (a_begins_r),
    .a_offset   (a_offset_r),
    .file_length(file_length_r),
    .res_valid  (res_valid),
    .res_tag    (res_tag),
    .res_start  (res_start),
    .res_size   (res_size)
  );

  mbhp_emit #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .res_valid(res_valid),
    .res_tag  (res_tag),
    .res_start(res_start),
    .res_size (res_size),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for media_box_header_parser_core
// feeds box header bytes on mbhp_in_if and checks parsed boxes on mbhp_out_if
// depends on mbhp_pkg, mbhp_in_if, mbhp_out_if and the parser rtl
`timescale 1ns / 1ps

module testbench;
  import mbhp_pkg::*;

  localparam int OFF_W           = 48;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int LONG_STALL      = 400;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_REPORTS     = 100;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic              begins_header;
    logic [OFF_W-1:0]  byte_offset;
  } hdr_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0] box_type;
    logic [OFF_W-1:0]  box_start;
    logic [SIZE_W-1:0] box_size;
    logic [SIZE_W-1:0] box_end;
    logic              not_letters;
  } box_result_t;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_MAIN, SCAN_EXT, SCAN_WIDE} scan_phase_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [FLEN_W-1:0] cfg_wdata;

  mbhp_in_if  #(.OFFSET_BITS(OFF_W)) in_chan ();
  mbhp_out_if #(.OFFSET_BITS(OFF_W)) out_chan ();

  media_box_header_parser_core #(.OFFSET_BITS(OFF_W)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  hdr_item_t   byte_queue[$];
  hdr_item_t   seq_bytes[$];
  box_result_t expected_boxes[$];

  // parser shadow state
  logic [FLEN_W-1:0] file_len    = '0;
  logic [SIZE_W-1:0] scan_window = '0;
  int                scan_count  = 0;
  scan_phase_t       scan_phase  = SCAN_IDLE;
  logic [OFF_W-1:0]  scan_start  = '0;
  logic [SIZE_W-1:0] wrap_size   = '0;
  logic [TYPE_W-1:0] scan_type   = '0;
  logic              scan_bad    = 1'b0;

  int send_idle_pct    = 0;
  int recv_idle_pct    = 0;
  int mismatches       = 0;
  int stall_left       = 0;
  bit long_stall_req   = 1'b0;
  bit long_stall_taken = 1'b0;
  bit parser_idle      = 1'b1;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [OFF_W-1:0] rand48();
    return {16'($urandom_range(16'hFFFF)), 32'($urandom())};
  endfunction

  function automatic logic has_non_letter(input logic [TYPE_W-1:0] t);
    logic [7:0] c;
    logic       bad;
    bad = 1'b0;
    for (int k = 0; k < 4; k++) begin
      c = t[8*k +: 8];
      if (!((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

  function automatic logic [SIZE_W-1:0] resolve_raw_size(input logic [31:0] raw,
                                                         input logic [OFF_W-1:0] start);
    if (raw == 32'd0) begin
      return {16'b0, file_len} - {16'b0, start};
    end
    if (raw < HDR_BYTES) begin
      return HDR_BYTES;
    end
    return {32'b0, raw};
  endfunction

  task automatic record_box(input logic [TYPE_W-1:0] typ, input logic [OFF_W-1:0] start,
                            input logic [SIZE_W-1:0] size, input logic bad);
    box_result_t r;
    r.box_type    = typ;
    r.box_start   = start;
    r.box_size    = size;
    r.box_end     = {16'b0, start} + size;
    r.not_letters = bad;
    expected_boxes.push_back(r);
    scan_phase = SCAN_IDLE;
    scan_count = 0;
  endtask

  task automatic parse_header_byte(input hdr_item_t it);
    logic [31:0]       raw;
    logic [TYPE_W-1:0] typ;
    logic [SIZE_W-1:0] sz;
    if (it.begins_header) begin
      scan_start  = it.byte_offset;
      scan_phase  = SCAN_MAIN;
      scan_count  = 0;
      scan_window = '0;
    end
    if (scan_phase == SCAN_IDLE) return;
    scan_window = {scan_window[SIZE_W-9:0], it.header_byte};
    scan_count++;
    if (scan_count < 8) return;
    scan_count = 0;
    raw = scan_window[63:32];
    typ = scan_window[31:0];
    case (scan_phase)
      SCAN_MAIN: begin
        scan_type = typ;
        scan_bad  = has_non_letter(typ);
        if (typ == WIDE_TAG) begin
          // wrapper: keep its size, the inner header follows 8 bytes later
          wrap_size   = resolve_raw_size(raw, scan_start);
          scan_start  = scan_start + OFF_W'(HDR_BYTES);
          scan_phase  = SCAN_WIDE;
          scan_window = '0;
        end else if (raw == EXT_SIZE) begin
          scan_phase  = SCAN_EXT;
          scan_window = '0;
        end else begin
          record_box(typ, scan_start, resolve_raw_size(raw, scan_start), scan_bad);
        end
      end
      SCAN_EXT: begin
        sz = (scan_window < HDR_BYTES) ? HDR_BYTES : scan_window;
        record_box(scan_type, scan_start, sz, scan_bad);
      end
      default: begin
        sz = wrap_size - HDR_BYTES;
        if (sz == '0) sz = resolve_raw_size(raw, scan_start);
        record_box(typ, scan_start, sz, has_non_letter(typ));
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS) $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_box();
    box_result_t want;
    if (expected_boxes.size() == 0) begin
      if (mismatches < MAX_REPORTS) begin
        $error("box_type: expected none, got %h at start %h", out_chan.box_type,
               out_chan.box_start);
      end
      mismatches++;
      return;
    end
    want = expected_boxes.pop_front();
    compare_field("box_type", 64'(want.box_type), 64'(out_chan.box_type));
    compare_field("box_start", 64'(want.box_start), 64'(out_chan.box_start));
    compare_field("box_size", want.box_size, out_chan.box_size);
    compare_field("box_end", want.box_end, out_chan.box_end);
    compare_field("type_not_letters", 64'(want.not_letters), 64'(out_chan.type_not_letters));
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        parse_header_byte(byte_queue.pop_front());
      end
      if (in_chan.valid && !in_chan.ready) begin
        // item still waiting, hold it
      end else if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_chan.valid         <= 1'b1;
        in_chan.header_byte   <= byte_queue[0].header_byte;
        in_chan.begins_header <= byte_queue[0].begins_header;
        in_chan.byte_offset   <= byte_queue[0].byte_offset;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // box monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) check_box();
      if (long_stall_req && !long_stall_taken) begin
        long_stall_taken = 1'b1;
        stall_left       = LONG_STALL;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic put_word(input logic [63:0] w, input logic first,
                          input logic [OFF_W-1:0] start);
    hdr_item_t it;
    for (int i = 0; i < 8; i++) begin
      it.header_byte   = w[63-8*i -: 8];
      it.begins_header = first && (i == 0);
      it.byte_offset   = (first && i == 0) ? start : rand48();
      seq_bytes.push_back(it);
    end
  endtask

  task automatic flush_sequence(input int n);
    for (int i = 0; i < n; i++) byte_queue.push_back(seq_bytes[i]);
    seq_bytes.delete();
  endtask

  function automatic logic [OFF_W-1:0] rand_start();
    case ($urandom_range(3))
      0:       return OFF_W'($urandom_range(4095));
      1:       return 48'hFFFF_FFFF_FFFF - OFF_W'($urandom_range(15));
      default: return rand48();
    endcase
  endfunction

  function automatic logic [31:0] rand_raw();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return EXT_SIZE;
      2:       return 32'($urandom_range(7, 2));
      3:       return 32'd8;
      4:       return 32'($urandom_range(4096, 9));
      5:       return 32'hFFFF_FFFF - 32'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size64();
    case ($urandom_range(3))
      0:       return 64'($urandom_range(15));
      1:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(15));
      2:       return 64'($urandom_range(65535));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [TYPE_W-1:0] rand_type();
    logic [TYPE_W-1:0] t;
    logic [7:0]        base;
    int                m;
    m = $urandom_range(9);
    if (m == 9) return WIDE_TAG;
    for (int k = 0; k < 4; k++) begin
      if (m == 6 || (m == 8 && $urandom_range(3) == 0)) begin
        t[8*k +: 8] = 8'($urandom());
      end else if (m == 7) begin
        // characters at and just either side of the letter range bounds
        case ($urandom_range(3))
          0:       base = 8'h41;
          1:       base = 8'h5a;
          2:       base = 8'h61;
          default: base = 8'h7a;
        endcase
        t[8*k +: 8] = base + 8'($urandom_range(2)) - 8'd1;
      end else if ($urandom_range(1) == 0) begin
        t[8*k +: 8] = 8'($urandom_range(8'h5a, 8'h41));
      end else begin
        t[8*k +: 8] = 8'($urandom_range(8'h7a, 8'h61));
      end
    end
    return t;
  endfunction

  task automatic add_random_traffic(input int target);
    int                done;
    int                pick;
    int                n;
    logic [31:0]       raw;
    logic [TYPE_W-1:0] typ;
    hdr_item_t         junk;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(99);
      if (pick < 6 && parser_idle) begin
        // stray bytes with no header start are dropped
        put_word({$urandom(), $urandom()}, 1'b0, '0);
        flush_sequence($urandom_range(3, 1));
      end else if (pick < 11) begin
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++) begin
          junk.header_byte   = 8'($urandom());
          junk.begins_header = ($urandom_range(3) == 0);
          junk.byte_offset   = rand48();
          byte_queue.push_back(junk);
        end
        done += n;
        parser_idle = 1'b0;
      end else begin
        raw = rand_raw();
        typ = rand_type();
        if (pick < 26) typ = WIDE_TAG;
        else if (pick < 40) raw = EXT_SIZE;
        put_word({raw, typ}, 1'b1, rand_start());
        if (typ == WIDE_TAG) put_word({rand_raw(), rand_type()}, 1'b0, '0);
        else if (raw == EXT_SIZE) put_word(rand_size64(), 1'b0, '0);
        if (pick >= 90) begin
          // header cut short, the next start restarts the parse
          n = $urandom_range(seq_bytes.size() - 1, 1);
          parser_idle = 1'b0;
        end else begin
          n = seq_bytes.size();
          parser_idle = 1'b1;
        end
        flush_sequence(n);
        done += n;
      end
    end
    if (!parser_idle) begin
      put_word({32'h10, "free"}, 1'b1, rand_start());
      flush_sequence(8);
      parser_idle = 1'b1;
    end
  endtask

  task automatic add_directed_boxes();
    put_word(64'hFF00_0000_0000_0000, 1'b0, '0);
    flush_sequence(2);
    put_word({32'h10, "moov"}, 1'b1, 48'h0);
    put_word({32'h0, "mdat"}, 1'b1, 48'h100);
    put_word({32'h0, "free"}, 1'b1, 48'hFFFF_FFFF_FFFF);
    put_word({32'h2, 32'h4041_5A5B}, 1'b1, 48'h20);
    put_word({32'h7, 32'h6061_7A7B}, 1'b1, 48'h28);
    put_word({32'h8, 32'h415A_617A}, 1'b1, 48'h30);
    put_word({32'hFFFF_FFFF, 32'h0}, 1'b1, 48'hFFFF_FFFF_FFFF);
    // extended sizes
    put_word({EXT_SIZE, 32'hFFFF_FFFF}, 1'b1, 48'h40);
    put_word(64'd7, 1'b0, '0);
    put_word({EXT_SIZE, "mdat"}, 1'b1, 48'h10);
    put_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
    put_word({EXT_SIZE, "skip"}, 1'b1, 48'h50);
    put_word(64'd8, 1'b0, '0);
    put_word({EXT_SIZE, "skip"}, 1'b1, 48'h58);
    put_word(64'd0, 1'b0, '0);
    // wide wrappers
    put_word({32'h18, WIDE_TAG}, 1'b1, 48'h200);
    put_word({32'h1234, "mdat"}, 1'b0, '0);
    put_word({32'h8, WIDE_TAG}, 1'b1, 48'h300);
    put_word({32'h0, "mdat"}, 1'b0, '0);
    put_word({EXT_SIZE, WIDE_TAG}, 1'b1, 48'h400);
    put_word({32'h20, "mdat"}, 1'b0, '0);
    put_word({32'h8, WIDE_TAG}, 1'b1, 48'h500);
    put_word({EXT_SIZE, "free"}, 1'b0, '0);
    put_word({32'h0, WIDE_TAG}, 1'b1, 48'h600);
    put_word({32'h5, "mdat"}, 1'b0, '0);
    put_word({32'h8, WIDE_TAG}, 1'b1, 48'hFFFF_FFFF_FFFC);
    put_word({32'h3, WIDE_TAG}, 1'b0, '0);
    flush_sequence(seq_bytes.size());
    // restart inside an extended size and inside a main header
    put_word({EXT_SIZE, "moof"}, 1'b1, 48'h700);
    put_word(64'hFFFF, 1'b0, '0);
    flush_sequence(11);
    put_word({32'h30, "trak"}, 1'b1, 48'h900);
    flush_sequence(5);
    put_word({32'h30, "moov"}, 1'b1, 48'h800);
    flush_sequence(8);
    parser_idle = 1'b1;
  endtask

  task automatic write_file_length(input logic [FLEN_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    file_len  = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int                ph;
    logic [FLEN_W-1:0] flen_val;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_chan.valid         = 1'b0;
    in_chan.header_byte   = '0;
    in_chan.begins_header = 1'b0;
    in_chan.byte_offset   = '0;
    out_chan.ready        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 62 : 0;
      recv_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 27 : 0;
      case (ph)
        0:       flen_val = 48'h0000_0010_0000;
        1:       flen_val = '1;
        2:       flen_val = '0;
        4:       flen_val = FLEN_W'($urandom_range(4096));
        default: flen_val = rand48();
      endcase
      write_file_length(flen_val);
      if (ph == 0) add_directed_boxes();
      // output held off while bytes keep coming so the pipeline backs up
      if (ph == 4) long_stall_req = 1'b1;
      add_random_traffic(ITEMS_PER_PHASE);
      while (byte_queue.size() != 0 || expected_boxes.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
rtl/mbhp_pkg.sv
rtl/mbhp_in_if.sv
rtl/mbhp_out_if.sv
rtl/mbhp_parse.sv
rtl/mbhp_emit.sv
rtl/media_box_header_parser_core.sv
tb/testbench.sv
